### hw/rtl/per_channel_dc_bias_removal_core_macros.svh
// Assertion macros shared by the checker of the DC bias removal core.
// Included by bare file name; defines nothing but the assertion forms.
`ifndef PER_CHANNEL_DC_BIAS_REMOVAL_CORE_MACROS_SVH
`define PER_CHANNEL_DC_BIAS_REMOVAL_CORE_MACROS_SVH

// Check a property at every rising edge outside reset.
`define DCBR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dcbr: assertion failed");

// Check a property at every rising edge, reset included.
`define DCBR_ASSERT_RESET(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dcbr: reset assertion failed");

`endif

### hw/rtl/dcbr_pkg.sv
// Shared constants and types of the per-channel DC bias removal core.
// No dependencies; used by the interfaces, the divider and the top level.
package dcbr_pkg;

  localparam int CHANNELS_MAX_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int SUM_BITS = 40;
  localparam int CNT_BITS = 35;
  localparam int CFG_BITS = 3;

  localparam logic [SUM_BITS-1:0] HALVE_LIMIT = 40'd10000000000;
  localparam logic [CNT_BITS-1:0] COUNT_START = 35'd10;

  // Request to the serial divider: magnitudes only, sign handled by the caller
  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [CNT_BITS-1:0] divisor;
  } dcbr_div_req_t;

  // Divider status: done pulses for one cycle with the quotient valid
  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } dcbr_div_rsp_t;

endpackage

### hw/rtl/dcbr_if.sv
// Valid/ready channel interfaces for samples in and corrected samples out.
// Depends on dcbr_pkg for default widths.
interface dcbr_sample_if
  import dcbr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_in_packet;

  modport source (output valid, output sample, output last_in_packet, input ready);
  modport sink (input valid, input sample, input last_in_packet, output ready);
endinterface

interface dcbr_result_if
  import dcbr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_BITS:0] corrected_sample;
  logic                 packet_end;

  modport source (output valid, output corrected_sample, output packet_end, input ready);
  modport sink (input valid, input corrected_sample, input packet_end, output ready);
endinterface

### hw/rtl/dcbr_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, SUM_BITS steps.
// Depends on dcbr_pkg for operand widths and the request/response structs.
module dcbr_serial_div
  import dcbr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  dcbr_div_req_t req,
  output dcbr_div_rsp_t rsp
);

  localparam int STEP_W = $clog2(SUM_BITS + 1);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   steps_left;
  logic [SUM_BITS-1:0] shift_q;
  logic [CNT_BITS-1:0] remainder;
  logic [CNT_BITS-1:0] divisor;

  logic [CNT_BITS:0]   rem_shift;
  logic [CNT_BITS+1:0] rem_diff;
  logic                q_bit;

  // Bring down the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_shift = {remainder, shift_q[SUM_BITS-1]};
    rem_diff  = {1'b0, rem_shift} - {2'b00, divisor};
    q_bit     = ~rem_diff[CNT_BITS+1];
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy       <= 1'b1;
        steps_left <= STEP_W'(SUM_BITS);
        shift_q    <= req.dividend;
        remainder  <= '0;
        divisor    <= req.divisor;
      end else if (busy) begin
        shift_q    <= {shift_q[SUM_BITS-2:0], q_bit};
        remainder  <= q_bit ? rem_diff[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
        steps_left <= steps_left - STEP_W'(1);
        if (steps_left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = shift_q;

endmodule

### hw/rtl/per_channel_dc_bias_removal_core.sv
// Per-channel DC bias removal: running mean per channel, subtracted per packet.
// Depends on dcbr_pkg, dcbr_if (channel interfaces) and dcbr_serial_div.
//
//   channel     | dir | payload                              | handshake
//   ------------+-----+--------------------------------------+-------------
//   audio       | in  | sample, last_in_packet               | valid/ready
//   corrected   | out | corrected_sample, packet_end         | valid/ready
//   cfg_write_* | in  | channel_count (3 bits)               | write enable
//
// A sample that is not its channel's first in the packet passes accept (S_IDLE)
// and the update step (S_UPD). A channel's first sample in a packet also runs
// the bit-serial divider (S_DIV) between the two. The packet's last sample adds
// a halving sweep over the sums of every channel slot (CHANNELS_MAX).
// Reset clears sums and sets counts to COUNT_START. A full output register
// stalls the update step; the next sample is taken while a result waits.
module per_channel_dc_bias_removal_core
  import dcbr_pkg::*;
#(
  parameter int CHANNELS_MAX = CHANNELS_MAX_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  dcbr_sample_if.sink         audio,
  dcbr_result_if.source       corrected,
  input  logic                cfg_write_en,
  input  logic [CFG_BITS-1:0] cfg_write_data
);

  localparam int CH_W  = (CHANNELS_MAX > 1) ? $clog2(CHANNELS_MAX) : 1;
  localparam int POS_W = $clog2(CHANNELS_MAX + 1);
  localparam int NCH_W = CFG_BITS + 1;

  localparam logic [NCH_W-1:0] NCH_MAX = NCH_W'(CHANNELS_MAX);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(CHANNELS_MAX);
  localparam logic [CH_W-1:0]  CH_LAST = CH_W'(CHANNELS_MAX - 1);

  localparam logic [SUM_BITS-1:0] Q_POS_LIM =
    SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SUM_BITS-1:0] Q_NEG_LIM = SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic [SAMPLE_BITS-1:0] OFS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OFS_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_UPD,
    S_HALVE
  } state_t;

  state_t                 state;
  logic [CFG_BITS-1:0]    channel_count;
  logic [SUM_BITS-1:0]    channel_sum        [CHANNELS_MAX];
  logic [CNT_BITS-1:0]    channel_count_seen [CHANNELS_MAX];
  logic [SAMPLE_BITS-1:0] channel_offset     [CHANNELS_MAX];
  logic [CH_W-1:0]        current_channel;
  logic [POS_W-1:0]       packet_position;
  logic [CH_W-1:0]        item_channel;
  logic [SAMPLE_BITS-1:0] item_sample;
  logic                   item_last;
  logic                   div_negative;
  logic                   div_zero;
  logic [CH_W-1:0]        halve_idx;
  logic                   out_valid;
  logic [SAMPLE_BITS:0]   out_sample;
  logic                   out_end;

  logic [NCH_W-1:0]       nch;
  logic [NCH_W-1:0]       cfg_ext;
  logic [CH_W-1:0]        ch_in;
  logic                   first_in;
  logic [CH_W-1:0]        rd_idx;
  logic [SUM_BITS-1:0]    rd_sum;
  logic [CNT_BITS-1:0]    rd_count;
  logic                   rd_neg;
  logic [SUM_BITS-1:0]    rd_mag;
  logic [SAMPLE_BITS-1:0] offset_next;
  logic [SUM_BITS-1:0]    sample_ext;
  logic [SUM_BITS:0]      sum_wide;
  logic [SUM_BITS-1:0]    sum_next;
  logic [CNT_BITS-1:0]    count_next;
  logic [SAMPLE_BITS:0]   corr;
  logic                   slot_free;
  logic                   over_limit;
  logic [SUM_BITS-1:0]    sum_round;
  logic [SUM_BITS-1:0]    sum_halved;
  logic [POS_W-1:0]       position_next;
  logic [CH_W-1:0]        channel_next;
  dcbr_div_req_t          div_req;
  dcbr_div_rsp_t          div_rsp;

  // Clamp the channel count register to the usable range
  always_comb begin
    cfg_ext = {1'b0, channel_count};
    if (cfg_ext == '0) begin
      nch = NCH_W'(1);
    end else if (cfg_ext > NCH_MAX) begin
      nch = NCH_MAX;
    end else begin
      nch = cfg_ext;
    end
  end

  // Channel of the incoming sample, and whether it opens the channel's packet
  assign ch_in    = (NCH_W'(current_channel) < nch) ? current_channel : '0;
  assign first_in = NCH_W'(packet_position) < nch;

  // Select the channel whose sum and count are read this cycle
  always_comb begin
    case (state)
      S_IDLE:  rd_idx = ch_in;
      S_HALVE: rd_idx = halve_idx;
      default: rd_idx = item_channel;
    endcase
  end

  assign rd_sum   = channel_sum[rd_idx];
  assign rd_count = channel_count_seen[rd_idx];
  assign rd_neg   = rd_sum[SUM_BITS-1];
  assign rd_mag   = rd_neg ? (~rd_sum + SUM_BITS'(1)) : rd_sum;

  // Start the divider on the magnitude of the sum
  assign div_req.start    = audio.valid && (state == S_IDLE) && first_in;
  assign div_req.dividend = rd_mag;
  assign div_req.divisor  = rd_count;

  dcbr_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Restore the sign of the quotient and saturate to the sample range
  always_comb begin
    if (div_zero) begin
      offset_next = '0;
    end else if (!div_negative) begin
      offset_next = (div_rsp.quotient > Q_POS_LIM) ? OFS_MAX :
                    div_rsp.quotient[SAMPLE_BITS-1:0];
    end else if (div_rsp.quotient > Q_NEG_LIM) begin
      offset_next = OFS_MIN;
    end else begin
      offset_next = ~div_rsp.quotient[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
    end
  end

  // Accumulate the sample with saturation, bump the count, correct the sample
  always_comb begin
    sample_ext = {{(SUM_BITS-SAMPLE_BITS){item_sample[SAMPLE_BITS-1]}}, item_sample};
    sum_wide   = {rd_sum[SUM_BITS-1], rd_sum} + {sample_ext[SUM_BITS-1], sample_ext};
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_BITS-1:0];
    end
    count_next = (&rd_count) ? rd_count : rd_count + CNT_BITS'(1);
    corr = {item_sample[SAMPLE_BITS-1], item_sample}
         - {channel_offset[item_channel][SAMPLE_BITS-1], channel_offset[item_channel]};
  end

  // Halve a channel whose sum magnitude or count passed the limit
  always_comb begin
    over_limit = (rd_mag > HALVE_LIMIT) || ({{(SUM_BITS-CNT_BITS){1'b0}}, rd_count} > HALVE_LIMIT);
    sum_round  = rd_sum + {{(SUM_BITS-1){1'b0}}, rd_neg};
    sum_halved = {sum_round[SUM_BITS-1], sum_round[SUM_BITS-1:1]};
  end

  // Advance position and channel rotation
  always_comb begin
    position_next = (packet_position < POS_MAX) ? packet_position + POS_W'(1)
                                                : packet_position;
    channel_next  = ((NCH_W'(item_channel) + NCH_W'(1)) >= nch) ? '0
                                                              : item_channel + CH_W'(1);
  end

  assign slot_free = !out_valid || corrected.ready;

  // Sequence one transaction: accept, divide if first, update, halve at packet end
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      channel_count   <= CFG_BITS'(1);
      current_channel <= '0;
      packet_position <= '0;
      halve_idx       <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < CHANNELS_MAX; i++) begin
        channel_sum[i]        <= '0;
        channel_count_seen[i] <= COUNT_START;
      end
    end else begin
      if (cfg_write_en) begin
        channel_count <= cfg_write_data;
      end
      // Drop the delivered result unless the update step refills the slot
      if (corrected.ready && (state != S_UPD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (audio.valid) begin
            item_sample  <= audio.sample;
            item_last    <= audio.last_in_packet;
            item_channel <= ch_in;
            div_negative <= rd_neg;
            div_zero     <= (rd_count == '0);
            state        <= first_in ? S_DIV : S_UPD;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            channel_offset[item_channel] <= offset_next;
            state                        <= S_UPD;
          end
        end
        S_UPD: begin
          if (slot_free) begin
            out_valid                        <= 1'b1;
            out_sample                       <= corr;
            out_end                          <= item_last;
            channel_sum[item_channel]        <= sum_next;
            channel_count_seen[item_channel] <= count_next;
            if (item_last) begin
              current_channel <= '0;
              packet_position <= '0;
              halve_idx       <= '0;
              state           <= S_HALVE;
            end else begin
              current_channel <= channel_next;
              packet_position <= position_next;
              state           <= S_IDLE;
            end
          end
        end
        S_HALVE: begin
          if (over_limit) begin
            channel_sum[halve_idx]        <= sum_halved;
            channel_count_seen[halve_idx] <= rd_count >> 1;
          end
          if (halve_idx == CH_LAST) begin
            state <= S_IDLE;
          end else begin
            halve_idx <= halve_idx + CH_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign audio.ready                = (state == S_IDLE);
  assign corrected.valid            = out_valid;
  assign corrected.corrected_sample = out_sample;
  assign corrected.packet_end       = out_end;

endmodule

### hw/rtl/dcbr_checker.sv
// Port-level checker for the DC bias removal core, bound to the top level.
// Depends on dcbr_pkg and the assertion macros header.
`include "per_channel_dc_bias_removal_core_macros.svh"

module dcbr_checker
  import dcbr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [SAMPLE_BITS:0] corrected_sample,
  input logic                 packet_end
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `DCBR_ASSERT_RESET(a_reset_clean, clk, rst |=> !out_valid && in_ready)
  `DCBR_ASSERT(a_one_item_at_a_time, clk, rst, in_acc |=> !in_ready)
  `DCBR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(corrected_sample) && $stable(packet_end))
  `DCBR_ASSERT(a_no_invented_result, clk, rst, out_valid |-> pending != 2'd0)
  `DCBR_ASSERT(a_bounded_backlog, clk, rst, pending != 2'd3)

endmodule

bind per_channel_dc_bias_removal_core dcbr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_dcbr_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (audio.valid),
  .in_ready         (audio.ready),
  .out_valid        (corrected.valid),
  .out_ready        (corrected.ready),
  .corrected_sample (corrected.corrected_sample),
  .packet_end       (corrected.packet_end)
);
